// File: sv/rfa_pkg.sv
package rfa_pkg;

  // Operation codes carried on in_tuser
  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_MUL = 2'd1,
    CMD_RED = 2'd2,
    CMD_CMP = 2'd3
  } cmd_t;

  // Operand pairings fed to the shared multiplier
  typedef enum logic [1:0] {
    SEL_AN_BD = 2'd0,
    SEL_BN_AD = 2'd1,
    SEL_AD_BD = 2'd2,
    SEL_AN_BN = 2'd3
  } mul_sel_t;

  // Multiplier digit: bits of the second operand consumed per cycle
  localparam int MUL_DIGIT = 8;

  // Commands from the controller to the datapath
  typedef struct packed {
    cmd_t     op;
    mul_sel_t mul_sel;
    logic     load;
    logic     mul_start;
    logic     red_start;
    logic     res_load;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mul_done;
    logic red_done;
    logic den_eq;
  } dp_stat_t;

endpackage

// File: sv/rfa_mul.sv
module rfa_mul #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [WORD_WIDTH-1:0] op_a,
  input  logic [WORD_WIDTH-1:0] op_b,
  output logic                  done,
  output logic [WORD_WIDTH-1:0] prod
);
  import rfa_pkg::*;

  localparam int STEPS = (WORD_WIDTH + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int SW    = $clog2(STEPS + 1);

  logic [WORD_WIDTH-1:0]           a_r;
  logic [WORD_WIDTH-1:0]           b_r;
  logic [WORD_WIDTH-1:0]           acc_r;
  logic [WORD_WIDTH-1:0]           acc_nxt;
  logic [WORD_WIDTH+MUL_DIGIT-1:0] term;
  logic [SW-1:0]                   cnt_r;
  logic                            busy_r;
  logic                            done_r;

  // One digit of the second operand times the shifted first operand
  always_comb begin
    term    = a_r * b_r[MUL_DIGIT-1:0];
    acc_nxt = acc_r + term[WORD_WIDTH-1:0];
  end

  // Accumulate the low word of the product, one digit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      a_r    <= op_a;
      b_r    <= op_b;
      acc_r  <= '0;
      cnt_r  <= SW'(STEPS);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      a_r   <= a_r << MUL_DIGIT;
      b_r   <= b_r >> MUL_DIGIT;
      cnt_r <= cnt_r - SW'(1);
      if (cnt_r == SW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: sv/rfa_lane.sv
module rfa_lane #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [WORD_WIDTH-1:0] num,
  input  logic [WORD_WIDTH-1:0] den,
  output logic                  done,
  output logic [WORD_WIDTH-1:0] res_num,
  output logic [WORD_WIDTH-1:0] res_den
);

  localparam int W  = WORD_WIDTH;
  localparam int KW = $clog2(W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_GCD,
    S_DIV
  } lane_state_t;

  lane_state_t   state_r;
  logic [W-1:0]  num_r, den_r;
  logic [W-1:0]  u_r, v_r, u_nxt, v_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [W-1:0]  g_r, g_fin;
  logic          gcd_end;
  logic [W-1:0]  qn_r, qd_r, qn_nxt, qd_nxt;
  logic [W-1:0]  remn_r, remd_r, remn_nxt, remd_nxt;
  logic [W:0]    tn, td;
  logic [KW-1:0] cnt_r;
  logic          done_r;
  logic [W-1:0]  res_num_r, res_den_r;

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    mag = x[W-1] ? (~x + W'(1)) : x;
  endfunction

  // Binary gcd step and one restoring division bit for each magnitude
  always_comb begin
    gcd_end = (u_r == '0) || (v_r == '0);
    g_fin   = (u_r == '0) ? (v_r << k_r) : (u_r << k_r);
    u_nxt   = u_r;
    v_nxt   = v_r;
    k_nxt   = k_r;
    if (!u_r[0] && !v_r[0]) begin
      u_nxt = u_r >> 1;
      v_nxt = v_r >> 1;
      k_nxt = k_r + KW'(1);
    end else if (!u_r[0]) begin
      u_nxt = u_r >> 1;
    end else if (!v_r[0]) begin
      v_nxt = v_r >> 1;
    end else if (u_r >= v_r) begin
      u_nxt = (u_r - v_r) >> 1;
    end else begin
      v_nxt = (v_r - u_r) >> 1;
    end

    tn = {remn_r, qn_r[W-1]};
    td = {remd_r, qd_r[W-1]};
    if (tn >= {1'b0, g_r}) begin
      remn_nxt = W'(tn - {1'b0, g_r});
      qn_nxt   = {qn_r[W-2:0], 1'b1};
    end else begin
      remn_nxt = tn[W-1:0];
      qn_nxt   = {qn_r[W-2:0], 1'b0};
    end
    if (td >= {1'b0, g_r}) begin
      remd_nxt = W'(td - {1'b0, g_r});
      qd_nxt   = {qd_r[W-2:0], 1'b1};
    end else begin
      remd_nxt = td[W-1:0];
      qd_nxt   = {qd_r[W-2:0], 1'b0};
    end
  end

  // Sequence gcd then division; hold the result until the next one is done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            num_r   <= num;
            den_r   <= den;
            u_r     <= mag(num);
            v_r     <= mag(den);
            k_r     <= '0;
            done_r  <= 1'b0;
            state_r <= S_GCD;
          end
        end
        S_GCD: begin
          if (gcd_end) begin
            g_r    <= g_fin;
            qn_r   <= mag(num_r);
            qd_r   <= mag(den_r);
            remn_r <= '0;
            remd_r <= '0;
            cnt_r  <= '0;
            if (g_fin == '0) begin
              // both zero: pass the fraction through
              res_num_r <= num_r;
              res_den_r <= den_r;
              done_r    <= 1'b1;
              state_r   <= S_IDLE;
            end else begin
              state_r <= S_DIV;
            end
          end else begin
            u_r <= u_nxt;
            v_r <= v_nxt;
            k_r <= k_nxt;
          end
        end
        S_DIV: begin
          qn_r   <= qn_nxt;
          qd_r   <= qd_nxt;
          remn_r <= remn_nxt;
          remd_r <= remd_nxt;
          cnt_r  <= cnt_r + KW'(1);
          if (cnt_r == KW'(W - 1)) begin
            res_num_r <= num_r[W-1] ? (~qn_nxt + W'(1)) : qn_nxt;
            res_den_r <= den_r[W-1] ? (~qd_nxt + W'(1)) : qd_nxt;
            done_r    <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done    = done_r;
  assign res_num = res_num_r;
  assign res_den = res_den_r;

endmodule

// File: sv/rfa_datapath.sv
module rfa_datapath #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rfa_pkg::dp_cmd_t      dp_cmd,
  output rfa_pkg::dp_stat_t     dp_stat,
  input  logic [WORD_WIDTH-1:0] a_num,
  input  logic [WORD_WIDTH-1:0] a_den,
  input  logic [WORD_WIDTH-1:0] b_num,
  input  logic [WORD_WIDTH-1:0] b_den,
  output logic [WORD_WIDTH-1:0] res_num,
  output logic [WORD_WIDTH-1:0] res_den,
  output logic                  is_equal
);
  import rfa_pkg::*;

  localparam int W = WORD_WIDTH;

  logic [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic [W-1:0] p0_r, p1_r, p2_r;
  logic [W-1:0] mul_a, mul_b, prod;
  logic         mul_done;
  logic         la_done, lb_done;
  logic [W-1:0] la_num, la_den, lb_num, lb_den;
  logic [W-1:0] rn_nxt, rd_nxt, rd_raw;
  logic         eq_nxt;
  logic [W-1:0] res_num_r, res_den_r;
  logic         is_eq_r;

  // Select multiplier operands
  always_comb begin
    unique case (dp_cmd.mul_sel)
      SEL_AN_BD: begin mul_a = an_r; mul_b = bd_r; end
      SEL_BN_AD: begin mul_a = bn_r; mul_b = ad_r; end
      SEL_AD_BD: begin mul_a = ad_r; mul_b = bd_r; end
      SEL_AN_BN: begin mul_a = an_r; mul_b = bn_r; end
      default:   begin mul_a = an_r; mul_b = bn_r; end
    endcase
  end

  rfa_mul #(.WORD_WIDTH(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dp_cmd.mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  rfa_lane #(.WORD_WIDTH(W)) u_lane_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dp_cmd.red_start),
    .num     (an_r),
    .den     (ad_r),
    .done    (la_done),
    .res_num (la_num),
    .res_den (la_den)
  );

  rfa_lane #(.WORD_WIDTH(W)) u_lane_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dp_cmd.red_start),
    .num     (bn_r),
    .den     (bd_r),
    .done    (lb_done),
    .res_num (lb_num),
    .res_den (lb_den)
  );

  // Capture operands and keep finished products
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      an_r <= a_num;
      ad_r <= a_den;
      bn_r <= b_num;
      bd_r <= b_den;
    end
    if (mul_done && !dp_cmd.mul_start) begin
      unique case (dp_cmd.mul_sel)
        SEL_AN_BD: p0_r <= prod;
        SEL_AN_BN: p0_r <= prod;
        SEL_BN_AD: p1_r <= prod;
        SEL_AD_BD: p2_r <= prod;
        default:   p2_r <= prod;
      endcase
    end
  end

  // Form the result word for the current operation
  always_comb begin
    rn_nxt = '0;
    rd_raw = W'(1);
    eq_nxt = 1'b0;
    unique case (dp_cmd.op)
      CMD_ADD: begin
        if (ad_r == bd_r) begin
          rn_nxt = an_r + bn_r;
          rd_raw = ad_r;
        end else begin
          rn_nxt = p0_r + p1_r;
          rd_raw = p2_r;
        end
      end
      CMD_MUL: begin
        rn_nxt = p0_r;
        rd_raw = p2_r;
      end
      CMD_RED: begin
        rn_nxt = la_num;
        rd_raw = la_den;
      end
      CMD_CMP: begin
        eq_nxt = (la_num == lb_num) && (la_den == lb_den);
      end
      default: begin
        rn_nxt = '0;
      end
    endcase
    // a zero denominator from add or multiply becomes one
    if ((dp_cmd.op == CMD_ADD || dp_cmd.op == CMD_MUL) && rd_raw == '0) begin
      rd_nxt = W'(1);
    end else begin
      rd_nxt = rd_raw;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (dp_cmd.res_load) begin
      res_num_r <= rn_nxt;
      res_den_r <= rd_nxt;
      is_eq_r   <= eq_nxt;
    end
  end

  assign dp_stat.mul_done = mul_done;
  assign dp_stat.red_done = la_done && lb_done;
  assign dp_stat.den_eq   = (ad_r == bd_r);
  assign res_num          = res_num_r;
  assign res_den          = res_den_r;
  assign is_equal         = is_eq_r;

endmodule

// File: sv/rfa_ctrl.sv
module rfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rfa_pkg::cmd_t     in_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output rfa_pkg::dp_cmd_t  dp_cmd,
  input  rfa_pkg::dp_stat_t dp_stat
);
  import rfa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_M0,
    S_M1,
    S_M2,
    S_RED,
    S_FINISH
  } ctrl_state_t;

  ctrl_state_t state_r;
  cmd_t        cmd_r;
  mul_sel_t    mul_sel_r;
  logic        mul_start_r;
  logic        red_start_r;
  logic        out_valid_r;
  logic        accept;
  logic        res_load;
  logic        mul_fin;
  logic        red_fin;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign res_load = (state_r == S_FINISH) && (!out_valid_r || out_ready);
  assign mul_fin  = dp_stat.mul_done && !mul_start_r;
  assign red_fin  = dp_stat.red_done && !red_start_r;

  // Sequence one transaction at a time through the multiplier, the reduce lanes, or straight to finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmd_r       <= CMD_ADD;
      mul_sel_r   <= SEL_AN_BD;
      mul_start_r <= 1'b0;
      red_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      red_start_r <= 1'b0;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r   <= in_cmd;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          unique case (cmd_r)
            CMD_ADD: begin
              if (dp_stat.den_eq) begin
                state_r <= S_FINISH;
              end else begin
                mul_sel_r   <= SEL_AN_BD;
                mul_start_r <= 1'b1;
                state_r     <= S_M0;
              end
            end
            CMD_MUL: begin
              mul_sel_r   <= SEL_AN_BN;
              mul_start_r <= 1'b1;
              state_r     <= S_M0;
            end
            CMD_RED, CMD_CMP: begin
              red_start_r <= 1'b1;
              state_r     <= S_RED;
            end
            default: state_r <= S_FINISH;
          endcase
        end
        S_M0: begin
          if (mul_fin) begin
            mul_start_r <= 1'b1;
            if (cmd_r == CMD_ADD) begin
              mul_sel_r <= SEL_BN_AD;
              state_r   <= S_M1;
            end else begin
              mul_sel_r <= SEL_AD_BD;
              state_r   <= S_M2;
            end
          end
        end
        S_M1: begin
          if (mul_fin) begin
            mul_sel_r   <= SEL_AD_BD;
            mul_start_r <= 1'b1;
            state_r     <= S_M2;
          end
        end
        S_M2: begin
          if (mul_fin) begin
            state_r <= S_FINISH;
          end
        end
        S_RED: begin
          if (red_fin) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (res_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign dp_cmd.op        = cmd_r;
  assign dp_cmd.mul_sel   = mul_sel_r;
  assign dp_cmd.load      = accept;
  assign dp_cmd.mul_start = mul_start_r;
  assign dp_cmd.red_start = red_start_r;
  assign dp_cmd.res_load  = res_load;

endmodule

// File: sv/rational_fraction_alu_top.sv
// Channel  Direction  Ports                              Contents
// in       slave      in_tvalid in_tready in_tdata       operands a and b
//                     in_tuser                           operation code
// out      master     out_tvalid out_tready out_tdata    result fraction and equal flag
//
// One transaction at a time. Add with equal denominators uses no products; add otherwise
// takes three serial products, multiply takes two. Reduce and compare run binary gcd and
// then a W-step division (W = WORD_WIDTH) on both lanes side by side. Reset is synchronous,
// active low. A full output register holds the controller in its final state; in_tready
// stays low.
module rational_fraction_alu_top #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // a_num, a_den, b_num, b_den from bit 0 up, zero padded to whole bytes
  input  logic [((4*WORD_WIDTH+7)/8)*8-1:0]       in_tdata,
  // cmd
  input  logic [1:0]                              in_tuser,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // res_num, res_den, is_equal from bit 0 up, zero padded to whole bytes
  output logic [((2*WORD_WIDTH+1+7)/8)*8-1:0]     out_tdata
);
  import rfa_pkg::*;

  localparam int W       = WORD_WIDTH;
  localparam int OUT_W   = ((2 * W + 1 + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - 2 * W - 1;

  dp_cmd_t      dp_cmd;
  dp_stat_t     dp_stat;
  logic [W-1:0] res_num;
  logic [W-1:0] res_den;
  logic         is_equal;

  rfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (cmd_t'(in_tuser)),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  rfa_datapath #(.WORD_WIDTH(W)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat),
    .a_num    (in_tdata[W-1:0]),
    .a_den    (in_tdata[2*W-1:W]),
    .b_num    (in_tdata[3*W-1:2*W]),
    .b_den    (in_tdata[4*W-1:3*W]),
    .res_num  (res_num),
    .res_den  (res_den),
    .is_equal (is_equal)
  );

  // Pack the result transaction
  assign out_tdata = {{OUT_PAD{1'b0}}, is_equal, res_den, res_num};

endmodule
